/* hw/rtl/dedup_two_class_task_queue_core_defines.svh */
// ----------------------------------------------------------------------------
// Task queue assertion macros
// Shared assertion helpers for the task queue checkers.
// ----------------------------------------------------------------------------
`ifndef DEDUP_TWO_CLASS_TASK_QUEUE_CORE_DEFINES_SVH
`define DEDUP_TWO_CLASS_TASK_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DTQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DTQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg
// Types, widths and codes shared by the two-class task queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

	// storage and field widths
	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = (CNT_W + 1 > 5) ? CNT_W + 1 : 5;
	localparam int KEY_W = 32;
	localparam int GEN_W = 32;
	localparam int CAP_W = 5;
	localparam int OP_W  = 2;
	localparam int ST_W  = 3;
	localparam int OCC_W = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_ENQ    = 2'd0;
	localparam logic [OP_W-1:0] OP_TAKE   = 2'd1;
	localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;
	localparam logic [OP_W-1:0] OP_STOP   = 2'd3;

	// result status codes
	localparam logic [ST_W-1:0] ST_QUEUED    = 3'd0;
	localparam logic [ST_W-1:0] ST_DUP       = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
	localparam logic [ST_W-1:0] ST_STOPPED   = 3'd3;
	localparam logic [ST_W-1:0] ST_TAKEN     = 3'd4;
	localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;
	localparam logic [ST_W-1:0] ST_CANCELLED = 3'd6;
	localparam logic [ST_W-1:0] ST_STOPDONE  = 3'd7;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key_tag;
		logic [GEN_W-1:0] generation;
		logic             urgent;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [KEY_W-1:0] out_key;
		logic [GEN_W-1:0] out_generation;
		logic             out_urgent;
		logic [OCC_W-1:0] dropped;
		logic [OCC_W-1:0] occupancy;
		logic [OCC_W-1:0] peak_occupancy;
	} rsp_t;

	// per-row control, fanned out to every cell of the row
	typedef struct packed {
		logic push;
		logic pop;
		logic mark;
		logic compact;
		logic flush;
	} cell_ctl_t;

	// row status seen by the sequencer
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             any_hit;
		logic             any_kill;
		logic [KEY_W-1:0] head_key;
		logic [GEN_W-1:0] head_gen;
	} row_stat_t;

endpackage

/* hw/rtl/dedup_two_class_task_queue_core.sv */
// Flow: an accepted request steps through the evaluate and execute states,
//   then respond, and its result is registered at the output; a cancel stays
//   in compaction, closing one gap per class per cycle, until no mark is left.
//   req_stall holds new requests off until the sequencer returns to idle.
// Reset: arst_n clears counts, stopped flag, peak and capacity (to 16) at once.
// ----------------------------------------------------------------------------
// dedup_two_class_task_queue_core
// Two-class bounded task queue with duplicate suppression, built from two
// rows of shifting cells and a small sequencer.
// ----------------------------------------------------------------------------
module dedup_two_class_task_queue_core import dtq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EVAL    = 3'd1;
	localparam logic [2:0] S_EXEC    = 3'd2;
	localparam logic [2:0] S_COMPACT = 3'd3;
	localparam logic [2:0] S_DONE    = 3'd4;

	logic [2:0]       state_q;
	logic [CAP_W-1:0] cap_q;
	logic             stopped_q;
	logic [SUM_W-1:0] peak_q;
	req_t             item_q;
	logic [ST_W-1:0]  status_q;
	logic [KEY_W-1:0] okey_q;
	logic [GEN_W-1:0] ogen_q;
	logic             ourg_q;
	logic [SUM_W-1:0] drop_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	cell_ctl_t        ctl_u, ctl_d;
	row_stat_t        stat_u, stat_d;
	logic [SUM_W-1:0] occ;
	logic [SUM_W-1:0] eff_cap;
	logic [SUM_W-1:0] cap_ext;
	logic             req_acc;
	logic             rsp_free;
	logic             enq_ok;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// occupancy and effective capacity
	assign occ     = SUM_W'(stat_u.cnt) + SUM_W'(stat_d.cnt);
	assign cap_ext = SUM_W'(cap_q);
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = SUM_W'(1);
		end else if (cap_ext > SUM_W'(DEPTH)) begin
			eff_cap = SUM_W'(DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign enq_ok = !stopped_q && !stat_u.any_hit && !stat_d.any_hit && (occ < eff_cap);

	// row control
	always_comb begin
		ctl_u = '0;
		ctl_d = '0;
		case (state_q)
			S_EVAL: begin
				ctl_u.mark = (item_q.op == OP_CANCEL);
				ctl_d.mark = (item_q.op == OP_CANCEL);
			end
			S_EXEC: begin
				case (item_q.op)
					OP_ENQ: begin
						ctl_u.push = enq_ok && item_q.urgent;
						ctl_d.push = enq_ok && !item_q.urgent;
					end
					OP_TAKE: begin
						ctl_u.pop = (stat_u.cnt != '0);
						ctl_d.pop = (stat_u.cnt == '0) && (stat_d.cnt != '0);
					end
					OP_STOP: begin
						ctl_u.flush = 1'b1;
						ctl_d.flush = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_COMPACT: begin
				ctl_u.compact = 1'b1;
				ctl_d.compact = 1'b1;
			end
			default: begin
			end
		endcase
	end

	dtq_row u_row_urg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_u),
		.key_in (item_q.key_tag),
		.gen_in (item_q.generation),
		.stat   (stat_u)
	);

	dtq_row u_row_def (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_d),
		.key_in (item_q.key_tag),
		.gen_in (item_q.generation),
		.stat   (stat_d)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_q <= req;
		end
	end

	// sequencer, stopped flag and peak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			stopped_q <= 1'b0;
			peak_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (item_q.op == OP_CANCEL) begin
						state_q <= S_COMPACT;
					end else begin
						state_q <= S_DONE;
					end
					if (item_q.op == OP_STOP) begin
						stopped_q <= 1'b1;
					end
					if (item_q.op == OP_ENQ && enq_ok && (occ + SUM_W'(1) > peak_q)) begin
						peak_q <= occ + SUM_W'(1);
					end
				end
				S_COMPACT: begin
					if (!stat_u.any_kill && !stat_d.any_kill) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result fields gathered during execute and compaction
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			okey_q <= '0;
			ogen_q <= '0;
			ourg_q <= 1'b0;
			drop_q <= '0;
			case (item_q.op)
				OP_ENQ: begin
					if (stopped_q) begin
						status_q <= ST_STOPPED;
					end else if (stat_u.any_hit || stat_d.any_hit) begin
						status_q <= ST_DUP;
					end else if (occ >= eff_cap) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_QUEUED;
					end
				end
				OP_TAKE: begin
					if (stat_u.cnt != '0) begin
						status_q <= ST_TAKEN;
						okey_q   <= stat_u.head_key;
						ogen_q   <= stat_u.head_gen;
						ourg_q   <= 1'b1;
					end else if (stat_d.cnt != '0) begin
						status_q <= ST_TAKEN;
						okey_q   <= stat_d.head_key;
						ogen_q   <= stat_d.head_gen;
					end else begin
						status_q <= ST_EMPTY;
					end
				end
				OP_CANCEL: begin
					status_q <= ST_CANCELLED;
				end
				default: begin
					status_q <= ST_STOPDONE;
					drop_q   <= occ;
				end
			endcase
		end else if (state_q == S_COMPACT) begin
			drop_q <= drop_q + SUM_W'(stat_u.any_kill) + SUM_W'(stat_d.any_kill);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && rsp_free) begin
			rsp_q.status         <= status_q;
			rsp_q.out_key        <= okey_q;
			rsp_q.out_generation <= ogen_q;
			rsp_q.out_urgent     <= ourg_q;
			rsp_q.dropped        <= OCC_W'(drop_q);
			rsp_q.occupancy      <= OCC_W'(occ);
			rsp_q.peak_occupancy <= OCC_W'(peak_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hw/rtl/dtq_cell.sv */
// ----------------------------------------------------------------------------
// dtq_cell
// One queue slot: holds a task, matches it against the current item and
// shifts toward the head on take or while closing a gap during cancel.
// ----------------------------------------------------------------------------
module dtq_cell import dtq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic             live,
	input  logic             sel,
	input  logic [KEY_W-1:0] key_in,
	input  logic [GEN_W-1:0] gen_in,
	input  logic [KEY_W-1:0] nxt_key,
	input  logic [GEN_W-1:0] nxt_gen,
	input  logic             nxt_kill,
	input  logic             chain_in,
	output logic [KEY_W-1:0] key,
	output logic [GEN_W-1:0] gen,
	output logic             kill,
	output logic             chain_out,
	output logic             hit
);

	logic [KEY_W-1:0] key_q;
	logic [GEN_W-1:0] gen_q;
	logic             kill_q;
	logic             hit_q;
	logic             shift;

	// a marked cell at or below this one opens a gap that we close
	assign chain_out = chain_in | kill_q;
	assign shift     = ctl.pop | (ctl.compact & chain_out);

	// slot payload
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q <= nxt_key;
			gen_q <= nxt_gen;
		end else if (ctl.push && sel) begin
			key_q <= key_in;
			gen_q <= gen_in;
		end
	end

	// cancel mark: older generation than the limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kill_q <= 1'b0;
		end else if (ctl.mark) begin
			kill_q <= live && (gen_q < gen_in);
		end else if (ctl.flush || ctl.pop) begin
			kill_q <= 1'b0;
		end else if (ctl.compact && chain_out) begin
			kill_q <= nxt_kill;
		end
	end

	// duplicate match, registered to cut the compare from the reduce
	always_ff @(posedge clk) begin
		hit_q <= live && (key_q == key_in) && (gen_q == gen_in);
	end

	assign key  = key_q;
	assign gen  = gen_q;
	assign kill = kill_q;
	assign hit  = hit_q;

endmodule

/* hw/rtl/dtq_row.sv */
// ----------------------------------------------------------------------------
// dtq_row
// One FIFO class: a row of cells with the head at cell zero and a count.
// ----------------------------------------------------------------------------
module dtq_row import dtq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [KEY_W-1:0] key_in,
	input  logic [GEN_W-1:0] gen_in,
	output row_stat_t        stat
);

	logic [CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0] key_a   [DEPTH];
	logic [GEN_W-1:0] gen_a   [DEPTH];
	logic [DEPTH-1:0] kill_v;
	logic [DEPTH-1:0] chain_v;
	logic [DEPTH-1:0] hit_v;

	// cells, each fed by its upper neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] nk;
		logic [GEN_W-1:0] ng;
		logic             nkill;
		logic             cin;

		if (i == DEPTH - 1) begin : g_top
			assign nk    = '0;
			assign ng    = '0;
			assign nkill = 1'b0;
		end else begin : g_mid
			assign nk    = key_a[i+1];
			assign ng    = gen_a[i+1];
			assign nkill = kill_v[i+1];
		end

		if (i == 0) begin : g_head
			assign cin = 1'b0;
		end else begin : g_body
			assign cin = chain_v[i-1];
		end

		dtq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.live      (CNT_W'(i) < cnt_q),
			.sel       (CNT_W'(i) == cnt_q),
			.key_in    (key_in),
			.gen_in    (gen_in),
			.nxt_key   (nk),
			.nxt_gen   (ng),
			.nxt_kill  (nkill),
			.chain_in  (cin),
			.key       (key_a[i]),
			.gen       (gen_a[i]),
			.kill      (kill_v[i]),
			.chain_out (chain_v[i]),
			.hit       (hit_v[i])
		);
	end

	// class count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.flush) begin
			cnt_q <= '0;
		end else if (ctl.push) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (ctl.pop || (ctl.compact && (|kill_v))) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign stat.cnt      = cnt_q;
	assign stat.any_hit  = |hit_v;
	assign stat.any_kill = |kill_v;
	assign stat.head_key = key_a[0];
	assign stat.head_gen = gen_a[0];

endmodule

/* hw/rtl/dtq_checker.sv */
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks on the task queue responses, bound to the top level.
// ----------------------------------------------------------------------------
`include "dedup_two_class_task_queue_core_defines.svh"

module dtq_checker import dtq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled response item holds its payload
	`DTQ_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp item changed while stalled")

	// task fields are zero unless a task was taken
	`DTQ_ASSERT_IMP(a_zero_task, rsp_valid && (rsp.status != ST_TAKEN), (rsp.out_key == '0) && (rsp.out_generation == '0) && !rsp.out_urgent, "task fields set on non-take item")

	// stop leaves the queue empty
	`DTQ_ASSERT_IMP(a_stop_empty, rsp_valid && (rsp.status == ST_STOPDONE), rsp.occupancy == '0, "occupancy nonzero after stop")

	// only cancel and stop report dropped tasks
	`DTQ_ASSERT_IMP(a_drop_zero, rsp_valid && (rsp.status != ST_CANCELLED) && (rsp.status != ST_STOPDONE), rsp.dropped == '0, "dropped set on wrong status")

	// occupancy never exceeds peak after a queued item
	`DTQ_ASSERT_IMP(a_peak_cover, rsp_valid && (rsp.status == ST_QUEUED), rsp.occupancy <= rsp.peak_occupancy, "occupancy above peak after enqueue")

endmodule

bind dedup_two_class_task_queue_core dtq_checker u_dtq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
